// ----- sv/lcs_pkg.sv -----
// Shared types and constants of the longest common substring block.
package lcs_pkg;

  // Width of the result position fields.
  localparam int unsigned POS_W = 7;
  localparam int unsigned SYM_W = 8;
  localparam int unsigned ACT_W = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_SOURCE = 2'd0,
    ACT_TARGET = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic append;
    logic scan_start;
    logic scan_step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic out_valid;
  } status_t;

endpackage

// ----- sv/lcs_ctrl.sv -----
// Controller state machine: input handshake and sequencing of the row scan.
module lcs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      action_i,
  input  logic            out_ready_i,
  input  lcs_pkg::status_t status_i,
  output lcs_pkg::cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  logic   is_finish;

  assign is_finish = (action_i == lcs_pkg::ACT_FINISH);

  // A finish transfer needs the output register free, or freed in this cycle.
  assign in_ready_o = (state_q == ST_IDLE) &&
                      (!is_finish || !status_i.out_valid || out_ready_i);
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o            = '0;
    cmd_o.append     = accept && (action_i == lcs_pkg::ACT_SOURCE);
    cmd_o.scan_start = accept && (action_i == lcs_pkg::ACT_TARGET) && !status_i.count_zero;
    cmd_o.finish     = accept && is_finish;
    cmd_o.scan_step  = (state_q == ST_SCAN);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.scan_start) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.scan_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_scan_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !in_ready_o)
    else $error("input ready during a row scan");

  a_scan_needs_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_start |=> (state_q == ST_SCAN))
    else $error("row scan did not start");

  a_one_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.append, cmd_o.scan_start, cmd_o.finish, cmd_o.scan_step}))
    else $error("more than one command at once");

endmodule

// ----- sv/lcs_datapath.sv -----
// Datapath: source store, run-length row memory, best tracking and result register.
module lcs_datapath #(
  parameter int unsigned MAX_SOURCE_LEN = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lcs_pkg::cmd_t               cmd_i,
  output lcs_pkg::status_t            status_o,
  input  logic [lcs_pkg::SYM_W-1:0]   symbol_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [lcs_pkg::POS_W-1:0]   match_length_o,
  output logic [lcs_pkg::POS_W-1:0]   match_start_o,
  output logic [lcs_pkg::POS_W-1:0]   match_end_o,
  output logic                        overflow_o
);

  localparam int unsigned CW = $clog2(MAX_SOURCE_LEN + 1);
  localparam int unsigned IW = $clog2(MAX_SOURCE_LEN);

  logic [lcs_pkg::SYM_W-1:0] store_mem [MAX_SOURCE_LEN];
  logic [CW-1:0]             run_mem   [MAX_SOURCE_LEN];

  logic [CW-1:0]             count_q, best_len_q, best_end_q;
  logic                      ovf_q;
  logic [IW-1:0]             idx_q;
  logic [CW-1:0]             prev_q;
  logic [lcs_pkg::SYM_W-1:0] target_q;
  logic [lcs_pkg::SYM_W-1:0] store_rd_q;
  logic [CW-1:0]             run_rd_q;
  logic                      out_valid_q;
  logic [lcs_pkg::POS_W-1:0] len_out_q, start_out_q, end_out_q;
  logic                      ovf_out_q;

  logic                      full;
  logic                      store_we;
  logic                      run_we;
  logic [IW-1:0]             run_wa;
  logic [CW-1:0]             run_wd;
  logic                      rd_en;
  logic [IW-1:0]             rd_addr;
  logic [CW-1:0]             end_pos;
  logic                      last;
  logic [CW-1:0]             cell_run;
  logic                      take_best;

  assign full     = (count_q == CW'(MAX_SOURCE_LEN));
  assign end_pos  = CW'(idx_q) + CW'(1);
  assign last     = (end_pos == count_q);
  assign cell_run = (store_rd_q == target_q) ? prev_q + CW'(1) : '0;

  // A longer run wins; an equal run wins only with a larger source end.
  assign take_best = cmd_i.scan_step && (cell_run != '0) &&
                     ((cell_run > best_len_q) ||
                      ((cell_run == best_len_q) && (end_pos > best_end_q)));

  assign store_we = cmd_i.append && !full;
  assign run_we   = store_we || cmd_i.scan_step;
  assign run_wa   = cmd_i.scan_step ? idx_q : count_q[IW-1:0];
  assign run_wd   = cmd_i.scan_step ? cell_run : '0;
  assign rd_en    = cmd_i.scan_start || (cmd_i.scan_step && !last);
  assign rd_addr  = cmd_i.scan_start ? '0 : idx_q + IW'(1);

  // Cells beyond the fill count are never read, so the row needs no clearing pass.
  always_ff @(posedge clk_i) begin
    if (store_we) store_mem[count_q[IW-1:0]] <= symbol_i;
    if (run_we) run_mem[run_wa] <= run_wd;
    if (rd_en) begin
      store_rd_q <= store_mem[rd_addr];
      run_rd_q   <= run_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      best_len_q  <= '0;
      best_end_q  <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.append) begin
        if (full) ovf_q <= 1'b1;
        else      count_q <= count_q + CW'(1);
      end
      if (cmd_i.scan_start) idx_q <= '0;
      else if (cmd_i.scan_step && !last) idx_q <= idx_q + IW'(1);
      if (take_best) begin
        best_len_q <= cell_run;
        best_end_q <= end_pos;
      end
      if (cmd_i.finish) begin
        count_q    <= '0;
        best_len_q <= '0;
        best_end_q <= '0;
        ovf_q      <= 1'b0;
      end
      if (cmd_i.finish)     out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      target_q <= symbol_i;
      prev_q   <= '0;
    end else if (cmd_i.scan_step) begin
      prev_q <= run_rd_q;
    end
    if (cmd_i.finish) begin
      len_out_q   <= lcs_pkg::POS_W'(best_len_q);
      start_out_q <= lcs_pkg::POS_W'(best_end_q - best_len_q);
      end_out_q   <= lcs_pkg::POS_W'(best_end_q);
      ovf_out_q   <= ovf_q;
    end
  end

  assign status_o.count_zero = (count_q == '0);
  assign status_o.scan_last  = last;
  assign status_o.out_valid  = out_valid_q;

  assign out_valid_o    = out_valid_q;
  assign match_length_o = len_out_q;
  assign match_start_o  = start_out_q;
  assign match_end_o    = end_out_q;
  assign overflow_o     = ovf_out_q;

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> (CW'(idx_q) < count_q))
    else $error("scan index beyond the stored source");

  a_best_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (best_end_q >= best_len_q) && (best_len_q <= count_q))
    else $error("best run inconsistent with its end or the source length");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (count_q == '0) && (best_len_q == '0) && !ovf_q)
    else $error("state not cleared after finish");

endmodule

// ----- sv/longest_common_substring.sv -----
// Top level of the longest common substring block.
// Usage: items arrive on the input channel (in_valid_i/in_ready_o) with an
// action and a symbol. A source transfer appends the byte to the source store;
// bytes beyond MAX_SOURCE_LEN are dropped and the overflow flag is set. A
// target transfer starts a scan of the run-length row, one stored source
// position per cycle through the store and row memories. Each position takes
// its left neighbour's old run plus one on a match. A finish transfer loads
// the result register and clears the source count, the best run and the
// overflow flag. The result stays on the output channel
// (out_valid_o/out_ready_i) until its transfer; source and target transfers
// go on while it waits, and a further finish waits until the register is
// free. After reset the block is empty and ready; the row memory needs no
// clearing, as cells past the fill count are never read.
module longest_common_substring #(
  parameter int unsigned MAX_SOURCE_LEN = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [lcs_pkg::ACT_W-1:0] action_i,
  input  logic [lcs_pkg::SYM_W-1:0] symbol_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [lcs_pkg::POS_W-1:0] match_length_o,
  output logic [lcs_pkg::POS_W-1:0] match_start_o,
  output logic [lcs_pkg::POS_W-1:0] match_end_o,
  output logic                      overflow_o
);

  lcs_pkg::cmd_t    cmd;
  lcs_pkg::status_t status;

  lcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lcs_datapath #(
    .MAX_SOURCE_LEN (MAX_SOURCE_LEN)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .symbol_i       (symbol_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .match_length_o (match_length_o),
    .match_start_o  (match_start_o),
    .match_end_o    (match_end_o),
    .overflow_o     (overflow_o)
  );

endmodule
